>>> hw/rtl/linear_interp_resampler_assert.svh
// assertion macros shared by the resampler rtl
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define LIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that must never be seen
`define LIR_ASSERT_NEVER(lbl, cond, msg) `LIR_ASSERT(lbl, !(cond), msg)
`else
`define LIR_ASSERT(lbl, prop, msg)
`define LIR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> hw/rtl/lir_pkg.sv
// types and constants shared by the resampler modules
package lir_pkg;

  // field widths
  localparam int unsigned TimeW  = 48;
  localparam int unsigned ValW   = 32;
  localparam int unsigned FrameW = 32;
  localparam int unsigned StepW  = 32;

  // result cap per sample
  localparam int unsigned MaxOut = 64;
  localparam int unsigned NCntW  = $clog2(MaxOut);

  // step reset value, 2.097152 s
  localparam logic [StepW-1:0] StepReset = StepW'(2097152);

  // multiplier: value magnitude times one time chunk per cycle
  localparam int unsigned ProdW     = ValW + TimeW;
  localparam int unsigned MulChunkW = 16;
  localparam int unsigned MulSteps  = TimeW / MulChunkW;
  localparam int unsigned MulCntW   = $clog2(MulSteps);

  // shared restoring divider
  localparam int unsigned DivW    = TimeW;
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam logic [DivCntW-1:0] DivItersInterp = DivCntW'(ValW);
  localparam logic [DivCntW-1:0] DivItersTrunc  = DivCntW'(DivW);

  typedef enum logic {
    CMD_START,
    CMD_RUN
  } cmd_kind_e;

  // classified sample handed from front to back
  typedef struct packed {
    cmd_kind_e         kind;
    logic [TimeW-1:0]  x0;
    logic [TimeW-1:0]  x1;
    logic [ValW-1:0]   y0;
    logic [ValW-1:0]   y1;
    logic [TimeW-1:0]  den;
    logic              den_zero;
    logic              dy_neg;
    logic [ValW-1:0]   mag;
  } cmd_t;

  // one output item
  typedef struct packed {
    logic [FrameW-1:0] frame_index;
    logic [ValW-1:0]   value;
    logic              last_of_run;
    logic              truncated;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [DivW-1:0]    rem;
    logic [DivW-1:0]    dvd;
    logic [DivW-1:0]    dvs;
    logic [DivCntW-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quo;
    logic [DivW-1:0] rem;
  } div_rsp_t;

endpackage

>>> hw/rtl/lir_front.sv
// front end: takes samples, keeps the previous one and classifies each item
module lir_front import lir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [TimeW-1:0] sample_time_i,
  input  logic [ValW-1:0]  sample_value_i,
  input  logic             start_req_i,
  input  logic             cq_full_i,
  output logic             cq_push_o,
  output cmd_t             cmd_o
);

  logic             have_prev_q, have_prev_d;
  logic [TimeW-1:0] prev_time_q, prev_time_d;
  logic [ValW-1:0]  prev_value_q, prev_value_d;
  logic             accept;
  logic [TimeW:0]   den_full;
  logic [ValW:0]    dy_fwd, dy_rev;

  assign accept    = push && !cq_full_i;
  assign full      = cq_full_i;
  assign cq_push_o = accept;

  // time span and value difference of the bracketing pair
  assign den_full = {1'b0, sample_time_i} - {1'b0, prev_time_q};
  assign dy_fwd   = {sample_value_i[ValW-1], sample_value_i}
                  - {prev_value_q[ValW-1], prev_value_q};
  assign dy_rev   = {prev_value_q[ValW-1], prev_value_q}
                  - {sample_value_i[ValW-1], sample_value_i};

  // build the command
  always_comb begin
    cmd_o.kind     = (start_req_i || !have_prev_q) ? CMD_START : CMD_RUN;
    cmd_o.x0       = prev_time_q;
    cmd_o.x1       = sample_time_i;
    cmd_o.y0       = prev_value_q;
    cmd_o.y1       = sample_value_i;
    cmd_o.den      = den_full[TimeW-1:0];
    cmd_o.den_zero = den_full[TimeW] || (den_full[TimeW-1:0] == '0);
    cmd_o.dy_neg   = dy_fwd[ValW];
    cmd_o.mag      = dy_fwd[ValW] ? dy_rev[ValW-1:0] : dy_fwd[ValW-1:0];
  end

  // previous sample update
  always_comb begin
    have_prev_d  = have_prev_q;
    prev_time_d  = prev_time_q;
    prev_value_d = prev_value_q;
    if (accept) begin
      have_prev_d  = 1'b1;
      prev_time_d  = sample_time_i;
      prev_value_d = sample_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else begin
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_time_q  <= prev_time_d;
    prev_value_q <= prev_value_d;
  end

endmodule

>>> hw/rtl/lir_cmd_queue.sv
// two-entry command queue between front and back
`include "linear_interp_resampler_assert.svh"
module lir_cmd_queue import lir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // the front must never push into a full queue
  `LIR_ASSERT(a_cq_no_overflow, push_i |-> !full_o, "command pushed into full queue")

endmodule

>>> hw/rtl/lir_div.sv
// restoring divider, one quotient bit per cycle, shared by interpolation and skip
`include "linear_interp_resampler_assert.svh"
module lir_div import lir_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    dvd_q, dvd_d;
  logic [DivW-1:0]    dvs_q, dvs_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW:0]      sh, diff;
  logic               ge;

  // one trial subtraction
  assign sh   = {rem_q, dvd_q[DivW-1]};
  assign diff = sh - {1'b0, dvs_q};
  assign ge   = (sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = busy_q && (cnt_q == DivCntW'(1));
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = req_i.rem;
      dvd_d  = req_i.dvd;
      dvs_d  = req_i.dvs;
      quo_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
      end
      rem_d = ge ? diff[DivW-1:0] : sh[DivW-1:0];
      dvd_d = {dvd_q[DivW-2:0], 1'b0};
      quo_d = {quo_q[DivW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    rsp_o.quo  = quo_q;
    rsp_o.rem  = rem_q;
  end

  // a new division never cuts into a running one
  `LIR_ASSERT(a_div_no_restart, req_i.start |-> !busy_q, "divider restarted while busy")

endmodule

>>> hw/rtl/lir_back.sv
// back end: output time sequencer, interpolation datapath and result queue
`include "linear_interp_resampler_assert.svh"
module lir_back import lir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [StepW-1:0] cfg_data_i,
  input  logic             cq_empty_i,
  input  cmd_t             cq_data_i,
  output logic             cq_pop_o,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i,
  output logic             empty_o,
  input  logic             pop_i,
  output res_t             res_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CHECK   = 4'd1;
  localparam logic [3:0] ST_NUM     = 4'd2;
  localparam logic [3:0] ST_MUL     = 4'd3;
  localparam logic [3:0] ST_DIVGO   = 4'd4;
  localparam logic [3:0] ST_DIV     = 4'd5;
  localparam logic [3:0] ST_VAL     = 4'd6;
  localparam logic [3:0] ST_EMIT    = 4'd7;
  localparam logic [3:0] ST_TRUNCGO = 4'd8;
  localparam logic [3:0] ST_TRUNC   = 4'd9;
  localparam logic [3:0] ST_FIX     = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  cmd_t               cur_q, cur_d;
  logic [TimeW:0]     t_q, t_d;
  logic [NCntW-1:0]   n_q, n_d;
  logic [FrameW-1:0]  frame_q, frame_d;
  logic [TimeW-1:0]   next_t_q, next_t_d;
  logic [TimeW-1:0]   num_q, num_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [MulCntW-1:0] mul_cnt_q, mul_cnt_d;
  logic [ValW-1:0]    q_q, q_d;
  logic [ValW-1:0]    val_q, val_d;
  logic [TimeW-1:0]   tmp_q, tmp_d;

  logic [StepW-1:0]          step_eff;
  logic [TimeW:0]            t_nxt, x1_ext, fix_t;
  logic                      at_cap, over, emit_last, emit_trunc;
  logic [TimeW:0]            num_diff;
  logic [TimeW-1:0]          num_clip;
  logic [ValW+MulChunkW-1:0] mul_pp;
  logic [ProdW-1:0]          prod_nxt;
  logic                      round_up;
  logic [ValW:0]             q_rnd;
  logic [ValW-1:0]           val_calc;
  logic [TimeW-1:0]          trunc_dvd;
  logic                      div_wait;

  res_t       oq_mem_q [2];
  logic       oq_wr_ptr_q, oq_rd_ptr_q;
  logic [1:0] oq_cnt_q, oq_cnt_d;
  logic       oq_full, oq_wr, oq_rd;
  res_t       res_w;

  // step register, zero acts as one
  always_comb begin
    step_d = cfg_we_i ? cfg_data_i : step_q;
  end
  assign step_eff = (step_q == '0) ? StepW'(1) : step_q;

  // output time bookkeeping
  assign x1_ext     = {1'b0, cur_q.x1};
  assign t_nxt      = t_q + (TimeW + 1)'(step_eff);
  assign at_cap     = (n_q == NCntW'(MaxOut - 1));
  assign over       = (t_nxt > x1_ext);
  assign emit_last  = at_cap || over;
  assign emit_trunc = at_cap && !over;
  assign trunc_dvd  = cur_q.x1 - t_q[TimeW-1:0];
  assign fix_t      = {1'b0, tmp_q} + (TimeW + 1)'(step_eff);

  // distance into the interval, clamped to its span
  assign num_diff = {1'b0, t_q[TimeW-1:0]} - {1'b0, cur_q.x0};
  always_comb begin
    if (num_diff[TimeW]) begin
      num_clip = '0;
    end else if (num_diff[TimeW-1:0] > cur_q.den) begin
      num_clip = cur_q.den;
    end else begin
      num_clip = num_diff[TimeW-1:0];
    end
  end

  // magnitude times one chunk of the distance, top chunk first
  assign mul_pp   = cur_q.mag * num_q[TimeW-1 -: MulChunkW];
  assign prod_nxt = {prod_q[ProdW-MulChunkW-1:0], {MulChunkW{1'b0}}} + ProdW'(mul_pp);

  // round half away from zero on the magnitude, then apply the sign
  assign round_up = ({div_rsp_i.rem, 1'b0} >= {1'b0, cur_q.den});
  assign q_rnd    = (ValW + 1)'(div_rsp_i.quo[ValW-1:0]) + (ValW + 1)'(round_up);
  assign val_calc = cur_q.dy_neg ? (cur_q.y0 - q_q) : (cur_q.y0 + q_q);

  assign res_w.frame_index = frame_q;
  assign res_w.value       = val_q;
  assign res_w.last_of_run = emit_last;
  assign res_w.truncated   = emit_trunc;

  // sequencer
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    t_d       = t_q;
    n_d       = n_q;
    frame_d   = frame_q;
    next_t_d  = next_t_q;
    num_d     = num_q;
    prod_d    = prod_q;
    mul_cnt_d = mul_cnt_q;
    q_d       = q_q;
    val_d     = val_q;
    tmp_d     = tmp_q;
    cq_pop_o  = 1'b0;
    oq_wr     = 1'b0;
    div_req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cq_empty_i) begin
          cq_pop_o = 1'b1;
          cur_d    = cq_data_i;
          if (cq_data_i.kind == CMD_START) begin
            next_t_d = cq_data_i.x1;
            frame_d  = '0;
          end else begin
            t_d     = {1'b0, next_t_q};
            n_d     = '0;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (t_q <= x1_ext) begin
          if (cur_q.den_zero) begin
            val_d   = cur_q.y1;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_NUM;
          end
        end else begin
          next_t_d = t_q[TimeW-1:0];
          state_d  = ST_IDLE;
        end
      end
      ST_NUM: begin
        num_d     = num_clip;
        prod_d    = '0;
        mul_cnt_d = '0;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        prod_d    = prod_nxt;
        num_d     = num_q << MulChunkW;
        mul_cnt_d = mul_cnt_q + MulCntW'(1);
        if (mul_cnt_q == MulCntW'(MulSteps - 1)) begin
          state_d = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        div_req_o.start = 1'b1;
        div_req_o.rem   = prod_q[ProdW-1:ValW];
        div_req_o.dvd   = {prod_q[ValW-1:0], {(DivW - ValW){1'b0}}};
        div_req_o.dvs   = cur_q.den;
        div_req_o.iters = DivItersInterp;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          q_d     = q_rnd[ValW-1:0];
          state_d = ST_VAL;
        end
      end
      ST_VAL: begin
        val_d   = val_calc;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!oq_full) begin
          oq_wr   = 1'b1;
          frame_d = frame_q + FrameW'(1);
          t_d     = t_nxt;
          n_d     = n_q + NCntW'(1);
          if (emit_trunc) begin
            state_d = ST_TRUNCGO;
          end else if (emit_last) begin
            next_t_d = t_nxt[TimeW-1:0];
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_TRUNCGO: begin
        div_req_o.start = 1'b1;
        div_req_o.rem   = '0;
        div_req_o.dvd   = trunc_dvd;
        div_req_o.dvs   = DivW'(step_eff);
        div_req_o.iters = DivItersTrunc;
        state_d         = ST_TRUNC;
      end
      ST_TRUNC: begin
        if (div_rsp_i.done) begin
          tmp_d   = cur_q.x1 - div_rsp_i.rem;
          frame_d = frame_q + div_rsp_i.quo[FrameW-1:0] + FrameW'(1);
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        next_t_d = fix_t[TimeW-1:0];
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result queue
  assign oq_full = (oq_cnt_q == 2'd2);
  assign empty_o = (oq_cnt_q == 2'd0);
  assign oq_rd   = pop_i && !empty_o;
  assign res_o   = oq_mem_q[oq_rd_ptr_q];

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_wr && !oq_rd) begin
      oq_cnt_d = oq_cnt_q + 2'd1;
    end else if (oq_rd && !oq_wr) begin
      oq_cnt_d = oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepReset;
      next_t_q    <= '0;
      frame_q     <= '0;
      n_q         <= '0;
      mul_cnt_q   <= '0;
      oq_wr_ptr_q <= 1'b0;
      oq_rd_ptr_q <= 1'b0;
      oq_cnt_q    <= 2'd0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      next_t_q    <= next_t_d;
      frame_q     <= frame_d;
      n_q         <= n_d;
      mul_cnt_q   <= mul_cnt_d;
      oq_wr_ptr_q <= oq_wr_ptr_q ^ oq_wr;
      oq_rd_ptr_q <= oq_rd_ptr_q ^ oq_rd;
      oq_cnt_q    <= oq_cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    t_q    <= t_d;
    num_q  <= num_d;
    prod_q <= prod_d;
    q_q    <= q_d;
    val_q  <= val_d;
    tmp_q  <= tmp_d;
    if (oq_wr) begin
      oq_mem_q[oq_wr_ptr_q] <= res_w;
    end
  end

  // sequencer states that wait on the divider
  assign div_wait = (state_q == ST_DIV) || (state_q == ST_TRUNC);

  // divider only finishes while the sequencer waits for it
  `LIR_ASSERT(a_div_done_waiting, div_rsp_i.done |-> div_wait, "divider done while not waiting")
  // a truncated result is always followed by the skip division
  `LIR_ASSERT(a_trunc_then_skip, oq_wr && emit_trunc |=> state_q == ST_TRUNCGO, "skip not started")
  // every emitted output time lies at or before the sample time
  `LIR_ASSERT_NEVER(a_emit_in_window, (state_q == ST_EMIT) && (t_q > x1_ext), "time past sample")

endmodule

>>> hw/rtl/linear_interp_resampler.sv
// linear_interp_resampler: top level, front end, command queue, back end, divider
// an interpolated item passes the command queue and the back-end check, multiply,
// 32-step shared divide, value and emit states; the divider paces a run's items
// equal or decreasing sample times skip multiply and divide; a cap skip adds
// the 48-step divide; a start sample only resets frame and next time, no item
// reset: asynchronous active low; clears queues, counters and step to 2097152
module linear_interp_resampler import lir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [TimeW-1:0]  sample_time_i,
  input  logic [ValW-1:0]   sample_value_i,
  input  logic              start_req_i,
  output logic              empty,
  input  logic              pop,
  output logic [FrameW-1:0] frame_index_o,
  output logic [ValW-1:0]   value_o,
  output logic              last_of_run_o,
  output logic              truncated_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [StepW-1:0]  cfg_data_i
);

  logic     cq_full, cq_push, cq_empty, cq_pop;
  cmd_t     cmd_in, cmd_out;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;

  // step register is always writable
  assign cfg_ready_o = 1'b1;

  lir_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .sample_time_i  (sample_time_i),
    .sample_value_i (sample_value_i),
    .start_req_i    (start_req_i),
    .cq_full_i      (cq_full),
    .cq_push_o      (cq_push),
    .cmd_o          (cmd_in)
  );

  lir_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cmd_in),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .data_o  (cmd_out)
  );

  lir_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lir_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cq_empty_i (cq_empty),
    .cq_data_i  (cmd_out),
    .cq_pop_o   (cq_pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  assign frame_index_o = res.frame_index;
  assign value_o       = res.value;
  assign last_of_run_o = res.last_of_run;
  assign truncated_o   = res.truncated;

endmodule
